@@ rtl/fss_pkg.sv @@
`default_nettype none

package fss_pkg;

  // query storage limits
  localparam int unsigned MaxQueryLen = 32;
  localparam int unsigned QueryRegs   = MaxQueryLen / 8;
  localparam int unsigned PosW        = 6;
  localparam int unsigned ScoreW      = 11;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;

  // score increments
  localparam logic [5:0] ScoreMatch    = 6'd10;
  localparam logic [5:0] ScoreRun      = 6'd20;
  localparam logic [5:0] ScoreBoundary = 6'd15;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegQuery0   = 3'd0,
    RegQuery1   = 3'd1,
    RegQuery2   = 3'd2,
    RegQuery3   = 3'd3,
    RegQueryLen = 3'd4
  } cfg_reg_e;

  typedef logic [7:0] char_t;

  // ascii upper case folds to lower case, all else unchanged
  function automatic char_t fold_case(input char_t c);
    char_t r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // whitespace or ascii punctuation other than $ + < = > ^ | ~ and backtick
  function automatic logic is_boundary(input char_t c);
    logic r;
    r = 1'b0;
    if (c inside {8'h20, [8'h09:8'h0D]}) begin
      r = 1'b1;
    end else if (c inside {[8'h21:8'h23], [8'h25:8'h2A], [8'h2C:8'h2F],
                           8'h3A, 8'h3B, 8'h3F, 8'h40,
                           [8'h5B:8'h5D], 8'h5F, 8'h7B, 8'h7D}) begin
      r = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fss_text_if.sv @@
`default_nettype none

interface fss_text_if;
  logic                valid;
  logic                ready;
  fss_pkg::char_t      text_char;
  logic                end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/fss_score_if.sv @@
`default_nettype none

interface fss_score_if;
  logic                        valid;
  logic                        ready;
  logic [fss_pkg::ScoreW-1:0]  match_score;
  logic                        fully_matched;

  modport source (output valid, output match_score, output fully_matched, input ready);
  modport sink   (input valid, input match_score, input fully_matched, output ready);
endinterface

`default_nettype wire

@@ rtl/fss_cfg_if.sv @@
`default_nettype none

interface fss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fss_pkg::CfgIdxW-1:0]   index;
  logic [fss_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/fuzzy_subsequence_scorer_top.sv @@
`default_nettype none

// fuzzy subsequence scorer
// text_i carries the target text one character per item, end_of_text set on
// the last one; score_o gives one result item per text: the score and whether
// every query character was matched in order, case-insensitively.
// cfg_i writes the query registers (indexes 0..3, eight characters each, first
// character in the lowest byte) and the length (index 4); other indexes are
// dropped. cfg_i is always ready; write it only while no text is in flight.
// a character is taken into an input register and scored from there against
// the next unmatched query character; the result of the last character is
// taken into the output register. throughput is one character per cycle,
// set by the single scoring stage, unless an end of text waits on score_o.
// when score_o is stalled the input register still drains characters that
// give no result; only a second end of text waits for the output register.
// reset clears the query to empty and the scan to the start of a text.
module fuzzy_subsequence_scorer_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  fss_text_if.sink     text_i,
  fss_score_if.source  score_o,
  fss_cfg_if.sink      cfg_i
);

  // configuration registers
  logic [fss_pkg::QueryRegs-1:0][fss_pkg::CfgDataW-1:0] query_q;
  logic [fss_pkg::PosW-1:0]                             len_q;
  logic [fss_pkg::MaxQueryLen-1:0][7:0]                 query_bytes;
  logic [fss_pkg::PosW-1:0]                             eff_len;

  assign cfg_i.ready = 1'b1;
  assign query_bytes = query_q;
  assign eff_len     = (len_q > fss_pkg::PosW'(fss_pkg::MaxQueryLen))
                       ? fss_pkg::PosW'(fss_pkg::MaxQueryLen) : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
      len_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fss_pkg::RegQuery0:   query_q[0] <= cfg_i.data;
        fss_pkg::RegQuery1:   query_q[1] <= cfg_i.data;
        fss_pkg::RegQuery2:   query_q[2] <= cfg_i.data;
        fss_pkg::RegQuery3:   query_q[3] <= cfg_i.data;
        fss_pkg::RegQueryLen: len_q      <= cfg_i.data[fss_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic           in_vld_q;
  fss_pkg::char_t char_q;
  logic           eot_q;
  logic           process;

  assign process      = in_vld_q && (!eot_q || !score_o.valid || score_o.ready);
  assign text_i.ready = !in_vld_q || process;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (text_i.ready) begin
      in_vld_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      char_q <= text_i.text_char;
      eot_q  <= text_i.end_of_text;
    end
  end

  // scan state
  logic [fss_pkg::PosW-1:0]   pos_q, pos_d;
  logic [fss_pkg::ScoreW-1:0] score_q, score_d;
  logic                       prev_q, prev_d;
  logic                       bound_q, bound_d;

  // scoring of the registered character
  fss_pkg::char_t             q_char;
  logic                       hit;
  logic [5:0]                 add;
  logic [fss_pkg::PosW-1:0]   pos_upd;
  logic [fss_pkg::ScoreW-1:0] score_upd;
  logic                       full;

  assign q_char = query_bytes[pos_q[fss_pkg::PosW-2:0]];
  assign hit    = (pos_q < eff_len) &&
                  (fss_pkg::fold_case(q_char) == fss_pkg::fold_case(char_q));
  assign add    = fss_pkg::ScoreMatch
                  + (prev_q  ? fss_pkg::ScoreRun      : 6'd0)
                  + (bound_q ? fss_pkg::ScoreBoundary : 6'd0);
  assign pos_upd   = hit ? pos_q + fss_pkg::PosW'(1) : pos_q;
  assign score_upd = hit ? score_q + fss_pkg::ScoreW'(add) : score_q;
  assign full      = pos_upd >= eff_len;

  // next scan state, back to the start after the last character
  always_comb begin
    pos_d   = pos_q;
    score_d = score_q;
    prev_d  = prev_q;
    bound_d = bound_q;
    if (process) begin
      if (eot_q) begin
        pos_d   = '0;
        score_d = '0;
        prev_d  = 1'b0;
        bound_d = 1'b1;
      end else begin
        pos_d   = pos_upd;
        score_d = score_upd;
        prev_d  = hit;
        bound_d = fss_pkg::is_boundary(char_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      score_q <= '0;
      prev_q  <= 1'b0;
      bound_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      score_q <= score_d;
      prev_q  <= prev_d;
      bound_q <= bound_d;
    end
  end

  // result register
  logic                       out_vld_q;
  logic [fss_pkg::ScoreW-1:0] out_score_q;
  logic                       out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process && eot_q) begin
      out_vld_q <= 1'b1;
    end else if (score_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && eot_q) begin
      out_score_q <= full ? score_upd : '0;
      out_full_q  <= full;
    end
  end

  assign score_o.valid         = out_vld_q;
  assign score_o.match_score   = out_score_q;
  assign score_o.fully_matched = out_full_q;

  // checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= fss_pkg::PosW'(fss_pkg::MaxQueryLen))
    else $error("query position beyond query storage");

  a_score_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (score_q == '0))
    else $error("score without any matched character");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_full_q) |-> (out_score_q == '0))
    else $error("partial match gave a nonzero score");

  a_scan_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && eot_q) |=> (pos_q == '0 && bound_q && !prev_q))
    else $error("scan state not cleared after last character");

endmodule

`default_nettype wire
